// ===== rtl/core/rkss_pkg.sv =====
// Package with the shared widths, register map and control types of the k-smallest sum block.
package rkss_pkg;

	// Field widths
	localparam int VALUE_W = 32;
	localparam int SUM_W   = 38;
	localparam int CFG_W   = 7;

	// Default number of cells in the chain
	localparam int MAX_KEEP_DEF = 64;

	// APB register map
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;
	localparam logic [APB_ADDR_W-1:0] ADDR_KEEP_COUNT = 2'd0;

	// Control word broadcast to every cell of the chain
	typedef struct packed {
		logic clear;   // drop all held values
		logic insert;  // the current item enters the chain
		logic grow;    // the chain gains one occupied cell
	} cell_ctrl_t;

endpackage

// ===== rtl/core/rkss_cell.sv =====
// One cell of the sorted insertion chain: holds one value and its occupied flag.
module rkss_cell #(
	parameter int IDX = 0,
	parameter int KW  = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rkss_pkg::cell_ctrl_t        ctrl,
	input  logic [rkss_pkg::VALUE_W-1:0] new_val,
	input  logic [KW-1:0]               eff_k,
	input  logic                        left_occ,
	input  logic [rkss_pkg::VALUE_W-1:0] left_val,
	output logic                        occ,
	output logic [rkss_pkg::VALUE_W-1:0] val,
	output logic                        tail_occ,
	output logic [rkss_pkg::VALUE_W-1:0] tail_val
);

	logic                         occ_q;
	logic [rkss_pkg::VALUE_W-1:0] val_q;
	logic                         is_last;
	logic [rkss_pkg::VALUE_W-1:0] val_next;

	// This cell is the last one kept when k equals its position plus one.
	assign is_last = (eff_k == KW'(IDX + 1));

	// Take the left neighbor's value when it is larger than the new item, else the
	// new item if this cell is empty or larger, else keep what is held.
	always_comb begin
		if (left_occ && (left_val > new_val)) begin
			val_next = left_val;
		end else if (!occ_q || (val_q > new_val)) begin
			val_next = new_val;
		end else begin
			val_next = val_q;
		end
	end

	// Occupied flag grows as a prefix from cell zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.clear) begin
			occ_q <= 1'b0;
		end else if (ctrl.grow) begin
			occ_q <= left_occ | (IDX == 0);
		end
	end

	// Held value; an empty cell may hold anything.
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			val_q <= val_next;
		end
	end

	assign occ      = occ_q;
	assign val      = val_q;
	assign tail_occ = is_last & occ_q;
	assign tail_val = is_last ? val_q : '0;

endmodule

// ===== rtl/core/running_k_smallest_sum.sv =====
// Top level of the streaming sum of the k smallest values, with its APB register.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall    value[31:0]
//  output    out        out_valid / out_stall  prior_sum[37:0], sum_valid
//  config    in         APB write, pready=1    keep_count at byte address 0
//
// One item is taken per clock unless stalled: every cell of the chain compares the item
// with its own value and its left neighbor's and shifts in the same cycle, so the chain
// and the running sum update at the edge the item is accepted. The result is registered
// and appears in the cycle after acceptance. A stalled result holds the input side off
// until it is taken. Reset clears the held set, the sum and keep_count; no clearing pass.
module running_k_smallest_sum #(
	parameter int MAX_KEEP = rkss_pkg::MAX_KEEP_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input item
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rkss_pkg::VALUE_W-1:0]    value,
	// result item
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rkss_pkg::SUM_W-1:0]      prior_sum,
	output logic                            sum_valid,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rkss_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rkss_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rkss_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int KW = $clog2(MAX_KEEP + 1);

	logic [rkss_pkg::CFG_W-1:0]   keep_count_q;
	logic [rkss_pkg::SUM_W-1:0]   running_sum_q;
	logic                         out_valid_q;
	logic [rkss_pkg::SUM_W-1:0]   prior_sum_q;
	logic                         sum_valid_q;

	logic                         cfg_wr;
	logic                         accept;
	logic [KW-1:0]                eff_k;
	logic                         full;
	logic [rkss_pkg::VALUE_W-1:0] largest;
	logic                         do_insert;
	logic [rkss_pkg::SUM_W-1:0]   sum_next;
	rkss_pkg::cell_ctrl_t         ctrl;

	logic                         occ_w      [MAX_KEEP];
	logic [rkss_pkg::VALUE_W-1:0] val_w      [MAX_KEEP];
	logic                         tail_occ_w [MAX_KEEP];
	logic [rkss_pkg::VALUE_W-1:0] tail_val_w [MAX_KEEP];

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr == rkss_pkg::ADDR_KEEP_COUNT);

	always_comb begin
		prdata = '0;
		if (paddr == rkss_pkg::ADDR_KEEP_COUNT) begin
			prdata = {{(rkss_pkg::APB_DATA_W - rkss_pkg::CFG_W){1'b0}}, keep_count_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= '0;
		end else if (cfg_wr) begin
			keep_count_q <= pwdata[rkss_pkg::CFG_W-1:0];
		end
	end

	// Keep count saturates at the number of cells.
	always_comb begin
		if (int'(keep_count_q) > MAX_KEEP) begin
			eff_k = KW'(MAX_KEEP);
		end else begin
			eff_k = KW'(keep_count_q);
		end
	end

	// The input side waits only while a finished result is stalled.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// Gather the last kept cell: its value is the largest held, its flag says the set is full.
	always_comb begin
		logic tail_any;
		tail_any = 1'b0;
		largest  = '0;
		for (int i = 0; i < MAX_KEEP; i++) begin
			tail_any = tail_any | tail_occ_w[i];
			largest  = largest | tail_val_w[i];
		end
		full = (eff_k == '0) | tail_any;
	end

	// An item enters while the set is short, or replaces the largest when it is smaller.
	assign do_insert = ~full | (value < largest);

	always_comb begin
		ctrl.clear  = cfg_wr;
		ctrl.insert = accept & do_insert;
		ctrl.grow   = accept & ~full;
	end

	// Running sum update.
	always_comb begin
		if (!full) begin
			sum_next = running_sum_q + rkss_pkg::SUM_W'(value);
		end else begin
			sum_next = running_sum_q + rkss_pkg::SUM_W'(value) - rkss_pkg::SUM_W'(largest);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
		end else if (cfg_wr) begin
			running_sum_q <= '0;
		end else if (ctrl.insert) begin
			running_sum_q <= sum_next;
		end
	end

	// The sorted chain, smallest value in cell zero.
	for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
		logic                         left_occ;
		logic [rkss_pkg::VALUE_W-1:0] left_val;

		if (g == 0) begin : g_head
			assign left_occ = 1'b0;
			assign left_val = '0;
		end else begin : g_body
			assign left_occ = occ_w[g-1];
			assign left_val = val_w[g-1];
		end

		rkss_cell #(
			.IDX (g),
			.KW  (KW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.new_val  (value),
			.eff_k    (eff_k),
			.left_occ (left_occ),
			.left_val (left_val),
			.occ      (occ_w[g]),
			.val      (val_w[g]),
			.tail_occ (tail_occ_w[g]),
			.tail_val (tail_val_w[g])
		);
	end

	// Result register: valid control with reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prior_sum_q <= full ? running_sum_q : '0;
			sum_valid_q <= full;
		end
	end

	assign out_valid = out_valid_q;
	assign prior_sum = prior_sum_q;
	assign sum_valid = sum_valid_q;

endmodule
